// ===== rtl/bchd_pkg.sv =====
// Package for the button click/hold detector: word types, time width,
// register indexes, reset values and click kind codes. No dependencies.
`default_nettype none

package bchd_pkg;

  // Width of the timestamp arithmetic; differences wrap modulo 2^TIME_BITS.
  localparam int TIME_BITS = 32;
  localparam int CFG_BITS  = 16;
  localparam int IDX_BITS  = 2;
  localparam int CNT_BITS  = 3;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CFG_BITS-1:0]  cfg_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [1:0]           kind_t;

  // Register indexes
  localparam logic [IDX_BITS-1:0] REG_DEBOUNCE    = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_MULTI_CLICK = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_HOLD        = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_INACTIVITY  = 2'd3;

  // Register reset values
  localparam cfg_t DEBOUNCE_RST    = 16'd50;
  localparam cfg_t MULTI_CLICK_RST = 16'd250;
  localparam cfg_t HOLD_RST        = 16'd500;
  localparam cfg_t INACTIVITY_RST  = 16'd2000;

  // Click kinds
  localparam kind_t KIND_NONE   = 2'd0;
  localparam kind_t KIND_SINGLE = 2'd1;
  localparam kind_t KIND_DOUBLE = 2'd2;
  localparam kind_t KIND_TRIPLE = 2'd3;

  localparam cnt_t CNT_MAX = 3'd7;

  typedef struct packed {
    logic        level;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic  press_event;
    logic  release_event;
    kind_t click_event_kind;
    logic  hold_start_event;
    logic  while_held;
    kind_t click_hold_kind;
    logic  pressed_state;
    logic  held_state;
    kind_t click_status;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/button_click_hold_detector_top.sv =====
// Button click/hold detector top level: input register, combinational update
// of the debounce/click/hold state and a result register. Uses bchd_pkg.
// Path: input reg, then the state update, then result reg; a word waits in the
//   input reg while the result reg is full and not being drained.
// Throughput: one word per cycle unless the receiver stalls; the whole state update
//   is a handful of wrapping subtractions and compares done between the two regs.
// Reset (rst_n low, synchronous): pipeline empty, debounced level released,
//   all timestamps, counts and flags zero, registers at their defaults.
`default_nettype none

module button_click_hold_detector_top (
  input  wire                   clk,
  input  wire                   rst_n,
  // input channel
  input  wire                   in_valid,
  output logic                  in_ready,
  input  bchd_pkg::in_word_t    in_data,
  // result channel
  output logic                  out_valid,
  input  wire                   out_ready,
  output bchd_pkg::out_word_t   out_data,
  // configuration write port
  input  wire                   cfg_we,
  input  wire [bchd_pkg::IDX_BITS-1:0] cfg_index,
  input  wire [bchd_pkg::CFG_BITS-1:0] cfg_wdata
);
  import bchd_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  cfg_t debounce_r, multi_click_r, hold_r, inactivity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= DEBOUNCE_RST;
      multi_click_r <= MULTI_CLICK_RST;
      hold_r        <= HOLD_RST;
      inactivity_r  <= INACTIVITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:    debounce_r    <= cfg_wdata;
        REG_MULTI_CLICK: multi_click_r <= cfg_wdata;
        REG_HOLD:        hold_r        <= cfg_wdata;
        REG_INACTIVITY:  inactivity_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: the input stage moves whenever the result reg is free or
  // is being drained this cycle. Both stages can hold a word at once.
  // ---------------------------------------------------------------------
  logic     in_v_r;
  in_word_t in_word_r;
  logic     out_v_r;
  out_word_t out_word_r;
  logic     advance;   // input-stage word is processed this cycle

  assign advance   = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || advance;
  assign out_valid = out_v_r;
  assign out_data  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_word_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------
  // Detector state
  // ---------------------------------------------------------------------
  logic  deb_level_r,   deb_level_nxt;
  time_t change_t_r,    change_t_nxt;
  time_t prev_change_r, prev_change_nxt;
  time_t press_t_r,     press_t_nxt;
  time_t last_click_r,  last_click_nxt;
  cnt_t  cnt_r,         cnt_nxt;
  logic  pressed_r,     pressed_nxt;
  logic  held_r,        held_nxt;
  logic [2:0] ch_flags_r, ch_flags_nxt;   // click-hold seen, one bit per kind
  kind_t status_r,      status_nxt;

  // ---------------------------------------------------------------------
  // Update logic
  // ---------------------------------------------------------------------
  time_t now;
  time_t el_change, el_prev_change, el_press, el_prev_press, el_last_click;
  time_t deb_w, multi_w, hold_w, inact_w;
  logic  run_end;
  cnt_t  cnt_run;          // count after the run-end check
  kind_t run_kind;
  out_word_t res;

  assign now     = TIME_BITS'(in_word_r.now_ms);
  assign deb_w   = TIME_BITS'(debounce_r);
  assign multi_w = TIME_BITS'(multi_click_r);
  assign hold_w  = TIME_BITS'(hold_r);
  assign inact_w = TIME_BITS'(inactivity_r);

  // wrapping differences
  assign el_change      = now - change_t_r;
  assign el_prev_change = now - prev_change_r;
  assign el_press       = now - press_t_r;
  assign el_prev_press  = now - press_t_r;   // press_t_r becomes prev on a press
  assign el_last_click  = now - last_click_r;

  // run ends once the window since the last click has passed; runs longer
  // than three clicks end silently
  assign run_end  = (el_last_click >= multi_w);
  assign cnt_run  = run_end ? '0 : cnt_r;
  assign run_kind = (run_end && (cnt_r inside {[3'd1:3'd3]})) ? cnt_r[1:0] : KIND_NONE;

  always_comb begin
    deb_level_nxt   = deb_level_r;
    change_t_nxt    = change_t_r;
    prev_change_nxt = prev_change_r;
    press_t_nxt     = press_t_r;
    last_click_nxt  = last_click_r;
    cnt_nxt         = cnt_r;
    pressed_nxt     = pressed_r;
    held_nxt        = held_r;
    ch_flags_nxt    = ch_flags_r;
    status_nxt      = status_r;
    res             = '0;

    if (in_word_r.level != deb_level_r) begin
      // level change: accepted only past the debounce time
      if (el_change > deb_w) begin
        deb_level_nxt   = in_word_r.level;
        prev_change_nxt = change_t_r;
        change_t_nxt    = now;
        if (!in_word_r.level) begin
          pressed_nxt       = 1'b1;
          res.press_event   = 1'b1;
          press_t_nxt       = now;
          last_click_nxt    = now;
          if (el_prev_press < multi_w) begin
            if (cnt_r < CNT_MAX) cnt_nxt = cnt_r + 3'd1;
          end else begin
            cnt_nxt = 3'd1;
          end
        end else begin
          pressed_nxt          = 1'b0;
          res.release_event    = 1'b1;
          held_nxt             = 1'b0;
          ch_flags_nxt         = '0;
          cnt_nxt              = cnt_run;
          res.click_event_kind = run_kind;
          if (run_kind != KIND_NONE) status_nxt = run_kind;
        end
      end
    end else begin
      // steady level: run end, then hold, then inactivity
      cnt_nxt              = cnt_run;
      res.click_event_kind = run_kind;
      if (run_kind != KIND_NONE) status_nxt = run_kind;

      if (!deb_level_r && (el_press > hold_w)) begin
        res.hold_start_event = !held_r;
        held_nxt             = 1'b1;
        res.while_held       = 1'b1;
        if (cnt_run == 3'd1 && !ch_flags_r[0]) begin
          ch_flags_nxt[0]     = 1'b1;
          res.click_hold_kind = KIND_SINGLE;
        end else if (cnt_run == 3'd2 && !ch_flags_r[1]) begin
          ch_flags_nxt[1]     = 1'b1;
          res.click_hold_kind = KIND_DOUBLE;
        end else if (cnt_run == 3'd3 && !ch_flags_r[2]) begin
          ch_flags_nxt[2]     = 1'b1;
          res.click_hold_kind = KIND_TRIPLE;
        end
      end

      // long idle clears count, status and click-hold flags, keeps held
      if (el_prev_change > inact_w) begin
        cnt_nxt      = '0;
        status_nxt   = KIND_NONE;
        ch_flags_nxt = '0;
      end
    end

    res.pressed_state = pressed_nxt;
    res.held_state    = held_nxt;
    res.click_status  = status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_level_r   <= 1'b1;
      change_t_r    <= '0;
      prev_change_r <= '0;
      press_t_r     <= '0;
      last_click_r  <= '0;
      cnt_r         <= '0;
      pressed_r     <= 1'b0;
      held_r        <= 1'b0;
      ch_flags_r    <= '0;
      status_r      <= KIND_NONE;
    end else if (advance) begin
      deb_level_r   <= deb_level_nxt;
      change_t_r    <= change_t_nxt;
      prev_change_r <= prev_change_nxt;
      press_t_r     <= press_t_nxt;
      last_click_r  <= last_click_nxt;
      cnt_r         <= cnt_nxt;
      pressed_r     <= pressed_nxt;
      held_r        <= held_nxt;
      ch_flags_r    <= ch_flags_nxt;
      status_r      <= status_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      out_v_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== verif/button_click_hold_detector_top_tb.sv =====
// Self-checking testbench for button_click_hold_detector_top: debounce, multi-click,
// hold and inactivity behavior checked word by word against an in-bench predictor.
// Depends on rtl/bchd_pkg.sv and rtl/button_click_hold_detector_top.sv.
`default_nettype none

module button_click_hold_detector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bchd_pkg::*;

  // Tracks the detector state, predicts one result word per sample word and
  // compares the block's results with the predictions in order.
  class click_hold_scoreboard;
    cfg_t      debounce, multi_click, hold, inactivity;
    logic      deb_level;
    time_t     change_t, prev_change_t, press_t, prev_press_t, last_click_t;
    cnt_t      clicks;
    logic      pressed, held;
    logic [2:0] hold_seen;     // one bit per click kind already reported as a hold
    kind_t     status;
    out_word_t expected_words[$];
    int        errors;

    function new();
      debounce      = DEBOUNCE_RST;
      multi_click   = MULTI_CLICK_RST;
      hold          = HOLD_RST;
      inactivity    = INACTIVITY_RST;
      deb_level     = 1'b1;
      change_t      = '0;
      prev_change_t = '0;
      press_t       = '0;
      prev_press_t  = '0;
      last_click_t  = '0;
      clicks        = '0;
      pressed       = 1'b0;
      held          = 1'b0;
      hold_seen     = '0;
      status        = KIND_NONE;
      errors        = 0;
    endfunction

    function void write_reg(logic [IDX_BITS-1:0] idx, cfg_t val);
      case (idx)
        REG_DEBOUNCE:    debounce = val;
        REG_MULTI_CLICK: multi_click = val;
        REG_HOLD:        hold = val;
        REG_INACTIVITY:  inactivity = val;
        default: ;
      endcase
    endfunction

    function time_t since(time_t now, time_t past);
      return now - past;
    endfunction

    // Closes the click run once the window has passed; returns the kind reported.
    function kind_t close_run(time_t now);
      kind_t k;
      k = KIND_NONE;
      if (since(now, last_click_t) >= multi_click) begin
        if (clicks >= 1 && clicks <= 3) begin
          k = kind_t'(clicks);
          status = k;
        end
        clicks = '0;
      end
      return k;
    endfunction

    // Predicts the result of one sample; returns 0 when the sample was ignored.
    function bit note_sample(in_word_t w);
      out_word_t r;
      time_t     now;
      bit        took;
      r    = '0;
      now  = w.now_ms;
      took = 1'b1;
      if (w.level != deb_level) begin
        if (since(now, change_t) > debounce) begin
          deb_level     = w.level;
          prev_change_t = change_t;
          change_t      = now;
          if (!w.level) begin
            pressed       = 1'b1;
            r.press_event = 1'b1;
            prev_press_t  = press_t;
            press_t       = now;
            if (since(now, prev_press_t) < multi_click) begin
              if (clicks < CNT_MAX) clicks++;
            end else begin
              clicks = 3'd1;
            end
            last_click_t = now;
          end else begin
            pressed            = 1'b0;
            r.release_event    = 1'b1;
            held               = 1'b0;
            hold_seen          = '0;
            r.click_event_kind = close_run(now);
          end
        end else begin
          took = 1'b0;   // bounce inside the debounce time
        end
      end else begin
        r.click_event_kind = close_run(now);
        if (!deb_level && since(now, press_t) > hold) begin
          if (!held) r.hold_start_event = 1'b1;
          held         = 1'b1;
          r.while_held = 1'b1;
          if (clicks == 1 && !hold_seen[0]) begin
            hold_seen[0]      = 1'b1;
            r.click_hold_kind = KIND_SINGLE;
          end else if (clicks == 2 && !hold_seen[1]) begin
            hold_seen[1]      = 1'b1;
            r.click_hold_kind = KIND_DOUBLE;
          end else if (clicks == 3 && !hold_seen[2]) begin
            hold_seen[2]      = 1'b1;
            r.click_hold_kind = KIND_TRIPLE;
          end
        end
        if (since(now, prev_change_t) > inactivity) begin
          clicks    = '0;
          status    = KIND_NONE;
          hold_seen = '0;
        end
      end
      r.pressed_state = pressed;
      r.held_state    = held;
      r.click_status  = status;
      expected_words.push_back(r);
      return took;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_field(string name, logic [1:0] got, logic [1:0] want);
      if (got !== want) report($sformatf("%s is %0d, predicted %0d", name, got, want));
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        report("result word with no prediction pending");
        return;
      end
      want = expected_words.pop_front();
      check_field("press_event",      2'(got.press_event),      2'(want.press_event));
      check_field("release_event",    2'(got.release_event),    2'(want.release_event));
      check_field("click_event_kind", got.click_event_kind,     want.click_event_kind);
      check_field("hold_start_event", 2'(got.hold_start_event), 2'(want.hold_start_event));
      check_field("while_held",       2'(got.while_held),       2'(want.while_held));
      check_field("click_hold_kind",  got.click_hold_kind,      want.click_hold_kind);
      check_field("pressed_state",    2'(got.pressed_state),    2'(want.pressed_state));
      check_field("held_state",       2'(got.held_state),       2'(want.held_state));
      check_field("click_status",     got.click_status,         want.click_status);
    endtask
  endclass

  localparam real CLK_PERIOD      = 12.0;
  localparam int  CYCLE_LIMIT     = 400000;  // far above the slowest legal run
  localparam int  LONG_STALL      = 150;     // receiver hold-off that backs up the block
  localparam int  NUM_PHASES      = 7;
  localparam int  ITEMS_PER_PHASE = 100;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_word_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_word_t           out_data;
  logic                cfg_we;
  logic [IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_wdata;

  click_hold_scoreboard sb;
  time_t                t_now;          // timestamp of the last sample sent
  int                   applied_words;  // samples that were not debounce bounces
  int                   cycles;
  bit                   steady_flow;    // no idling on either side while set
  bit                   long_stall_req; // asks the receiver for one long hold-off

  button_click_hold_detector_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: a hang or a lost result word ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result monitor: every word taken off the result channel is checked in order.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Receiver: mostly ready, short and occasional long stalls, one very long
  // hold-off on request so the pipeline fills and in_ready drops.
  initial begin
    int unsigned stall_left;
    int unsigned pick;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left     = LONG_STALL;
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (steady_flow) begin
        out_ready = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          out_ready = 1'b1;
        end else begin
          out_ready  = 1'b0;
          stall_left = (pick < 93) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        end
      end
    end
  end

  // Sender idle gap after a word: mostly none, some short, a few long.
  function automatic int unsigned gap_len();
    int unsigned pick;
    if (steady_flow) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one sample word and holds it until accepted. Called and returns at
  // a falling edge; valid stays high when the next word follows directly.
  task automatic send_word(in_word_t w);
    int unsigned gap;
    in_data  = w;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.note_sample(w)) applied_words++;
    @(negedge clk);
    gap = gap_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic sample_at(logic lvl, time_t at);
    in_word_t w;
    t_now    = at;
    w.level  = lvl;
    w.now_ms = at;
    send_word(w);
  endtask

  task automatic sample(logic lvl, int unsigned dt);
    sample_at(lvl, t_now + time_t'(dt));
  endtask

  // Waits until every predicted word has come back and the two-stage pipeline
  // is surely empty before a register write.
  task automatic wait_for_quiet();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_BITS-1:0] idx, cfg_t val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_regs(cfg_t deb, cfg_t multi, cfg_t hld, cfg_t inact);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_MULTI_CLICK, multi);
    write_reg(REG_HOLD, hld);
    write_reg(REG_INACTIVITY, inact);
  endtask

  // Time step just past a threshold: always clears it.
  function automatic int unsigned over_dt(cfg_t v);
    return int'(v) + 1 + $urandom_range(0, int'(v) / 8 + 3);
  endfunction

  // Time step around a threshold: exactly on it, one either side, or anywhere
  // up to twice the value plus two, so the compares see both outcomes and the edge.
  function automatic int unsigned edge_dt(cfg_t v);
    case ($urandom_range(0, 4))
      0:       return int'(v);
      1:       return int'(v) + 1;
      2:       return (v == 0) ? 0 : int'(v) - 1;
      default: return $urandom_range(0, 2 * int'(v) + 2);
    endcase
  endfunction

  // A well-formed run of clicks with random timing: contact bounce now and
  // then, an optional hold on the last press, then idle samples that close
  // the run and sometimes reach the inactivity time.
  task automatic click_burst();
    int unsigned n;
    int unsigned k;
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      if (i == 0) sample(1'b0, edge_dt(sb.multi_click) + over_dt(sb.debounce));
      else        sample(1'b0, over_dt(sb.debounce));
      // bounce back to released, still inside the debounce time
      if ($urandom_range(0, 3) == 0) sample(1'b1, $urandom_range(0, int'(sb.debounce)));
      if (i == n - 1 && $urandom_range(0, 2) == 0) begin
        k = $urandom_range(1, 5);
        repeat (k) begin
          if ($urandom_range(0, 1)) sample(1'b0, edge_dt(sb.hold));
          else                      sample(1'b0, $urandom_range(0, int'(sb.hold) / 2 + 1));
        end
      end
      sample(1'b1, over_dt(sb.debounce));
    end
    k = $urandom_range(1, 3);
    repeat (k) sample(1'b1, edge_dt(sb.multi_click));
    if ($urandom_range(0, 4) == 0) sample(1'b1, edge_dt(sb.inactivity));
  endtask

  // Noise: random levels, zero or tiny steps, and full-width jumps that wrap
  // the timestamp and toggle every bit of it.
  task automatic noise_burst();
    int unsigned k;
    int unsigned dt;
    k = $urandom_range(1, 6);
    repeat (k) begin
      case ($urandom_range(0, 3))
        0:       dt = 0;
        1:       dt = $urandom_range(0, 3);
        2:       dt = $urandom_range(0, 70000);
        default: dt = $urandom();
      endcase
      sample(logic'($urandom_range(0, 1)), dt);
    end
  endtask

  initial begin
    int phase_start;
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    cycles         = 0;
    applied_words  = 0;
    t_now          = '0;
    steady_flow    = 1'b1;
    long_stall_req = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset register values (50/250/500/2000).
    sample_at(1'b1, 32'd0);        // steady at time zero
    sample_at(1'b0, 32'd10);       // bounce inside the debounce time
    sample_at(1'b0, 32'd51);       // press accepted, run starts
    sample_at(1'b0, 32'd600);      // run closes as single while held: hold start
    sample_at(1'b1, 32'd650);      // release clears the held flag
    for (int i = 0; i < 4; i++) begin
      sample_at(1'b0, time_t'(710 + 120 * i));   // four quick clicks
      sample_at(1'b1, time_t'(770 + 120 * i));
    end
    sample_at(1'b1, 32'd1430);     // four-click run ends with no kind
    sample_at(1'b1, 32'd4000);     // inactivity clears status
    sample_at(1'b0, 32'hFFFF_FFF0);
    sample_at(1'b1, 32'hFFFF_FFFF); // bounce at the top of the time range
    sample_at(1'b1, 32'h0000_0030); // release across the wrap

    // Hold shorter than the click window so click-specific holds can fire.
    wait_for_quiet();
    write_reg(REG_HOLD, 16'd100);
    sample_at(1'b0, 32'h200);       // single press
    sample_at(1'b0, 32'h200 + 120); // single-click hold
    sample_at(1'b1, 32'h200 + 180);
    sample_at(1'b0, 32'h200 + 240); // second press inside the window
    sample_at(1'b0, 32'h200 + 360); // double-click hold
    sample_at(1'b1, 32'h200 + 420);
    sample_at(1'b1, 32'h200 + 800); // double click reported

    // Random part: one register setting per phase, extremes included.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_quiet();
      case (p)
        0: set_regs(DEBOUNCE_RST, MULTI_CLICK_RST, HOLD_RST, INACTIVITY_RST);
        1: set_regs(16'd0, 16'd0, 16'd0, 16'd0);
        2: set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: set_regs(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        4: set_regs(cfg_t'($urandom_range(0, 300)), cfg_t'($urandom_range(0, 300)),
                    cfg_t'($urandom_range(0, 300)), cfg_t'($urandom_range(0, 300)));
        5: set_regs(cfg_t'($urandom()), cfg_t'($urandom()),
                    cfg_t'($urandom()), cfg_t'($urandom()));
        default: set_regs(16'd20, 16'd400, 16'd300, 16'd1500);
      endcase
      steady_flow = (p == 2);
      t_now       = $urandom();
      if (p == 0) long_stall_req = 1'b1;   // back up the pipeline once
      phase_start = applied_words;
      while (applied_words - phase_start < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 4) == 0) noise_burst();
        else                           click_burst();
      end
    end

    wait_for_quiet();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
